/* rtl/pdrs_pkg.sv */
// Shared types and constants of the per-destination resend scheduler.
package pdrs_pkg;

  localparam int MAX_RESULTS = 8;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam logic CMD_ENQ  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef enum logic [1:0] {
    EV_SEND    = 2'd0,
    EV_TIMEOUT = 2'd1,
    EV_FULL    = 2'd2
  } ev_kind_t;

  typedef enum logic [1:0] {
    CFG_OWN_ID  = 2'd0,
    CFG_MASK    = 2'd1,
    CFG_TIMEOUT = 2'd2,
    CFG_RESEND  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] own_id;
    logic [7:0]  mask;
    logic [15:0] timeout;
    logic [15:0] resend;
  } cfg_t;

  // Stored message: stamp in the upper word, then source, then handle.
  typedef struct packed {
    logic [31:0] stamp;
    logic [15:0] source;
    logic [15:0] handle;
  } msg_t;

  typedef struct packed {
    logic start;
    logic rd_en;
    logic proc_en;
    logic flush;
  } dp_cmd_t;

  typedef struct packed {
    logic blocked;
    logic pend_v;
    logic out_free;
  } dp_sts_t;

endpackage

/* rtl/pdrs_in_if.sv */
// Input item channel of the resend scheduler.
interface pdrs_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [15:0] message_handle;
  logic [15:0] source_id;
  logic [31:0] time_stamp;
  logic [15:0] delta_ticks;

  modport source (output valid, command, message_handle, source_id, time_stamp, delta_ticks,
                  input ready);
  modport sink   (input valid, command, message_handle, source_id, time_stamp, delta_ticks,
                  output ready);
endinterface

/* rtl/pdrs_out_if.sv */
// Result event channel of the resend scheduler.
interface pdrs_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [2:0]  dest_slot;
  logic [15:0] out_handle;
  logic [31:0] out_stamp;
  logic [15:0] out_source;
  logic [15:0] sender_id;
  logic        last_event;

  modport source (output valid, event_kind, dest_slot, out_handle, out_stamp, out_source,
                  sender_id, last_event, input ready);
  modport sink   (input valid, event_kind, dest_slot, out_handle, out_stamp, out_source,
                  sender_id, last_event, output ready);
endinterface

/* rtl/pdrs_cfg_if.sv */
// Configuration write channel of the resend scheduler.
interface pdrs_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/per_destination_resend_scheduler_unit.sv */
// Top level of the per-destination resend scheduler: config registers, sequencer, datapath.
//
//   channel  dir  handshake        beat
//   in_ch    in   valid/ready      command, handle, source, stamp, delta ticks
//   out_ch   out  valid/ready      one event: kind, slot, message fields, sender, last flag
//   cfg_ch   in   valid/ready      register index and write data (always ready)
//
// An item is accepted, then each slot in turn passes through the store read port and the
// process stage, and the flush state hands over the last event.
// Each slot stage stalls while a new event meets a held event and a full output register.
// Reset clears queue pointers, counts and head timers; the message store is not cleared.
module per_destination_resend_scheduler_unit
  import pdrs_pkg::*;
#(
  parameter int SLOTS      = 8,
  parameter int FIFO_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  pdrs_in_if.sink    in_ch,
  pdrs_out_if.source out_ch,
  pdrs_cfg_if.sink   cfg_ch
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  cfg_t          cfg_r;
  dp_cmd_t       cmd;
  dp_sts_t       sts;
  logic [SW-1:0] rd_slot;
  logic [SW-1:0] proc_slot;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_id  <= 16'd0;
      cfg_r.mask    <= 8'd0;
      cfg_r.timeout <= 16'd5000;
      cfg_r.resend  <= 16'd500;
    end else if (cfg_ch.valid) begin
      case (cfg_idx_t'(cfg_ch.index))
        CFG_OWN_ID:  cfg_r.own_id  <= cfg_ch.data;
        CFG_MASK:    cfg_r.mask    <= cfg_ch.data[7:0];
        CFG_TIMEOUT: cfg_r.timeout <= cfg_ch.data;
        CFG_RESEND:  cfg_r.resend  <= cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  pdrs_ctrl #(
    .SLOTS (SLOTS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .cmd       (cmd),
    .rd_slot   (rd_slot),
    .proc_slot (proc_slot),
    .sts       (sts)
  );

  pdrs_dp #(
    .SLOTS      (SLOTS),
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .rd_slot    (rd_slot),
    .proc_slot  (proc_slot),
    .sts        (sts),
    .cfg        (cfg_r),
    .in_command (in_ch.command),
    .in_handle  (in_ch.message_handle),
    .in_source  (in_ch.source_id),
    .in_stamp   (in_ch.time_stamp),
    .in_delta   (in_ch.delta_ticks),
    .out_ch     (out_ch)
  );

endmodule

/* rtl/pdrs_ctrl.sv */
// Sequencer: walks the slots through the read and process stages of the datapath.
module pdrs_ctrl
  import pdrs_pkg::*;
#(
  parameter int SLOTS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  output dp_cmd_t                               cmd,
  output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] rd_slot,
  output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] proc_slot,
  input  dp_sts_t                               sts
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  state_t        state_r, state_nxt;
  logic [SW:0]   rd_cnt_r, rd_cnt_nxt;
  logic          proc_v_r, proc_v_nxt;
  logic [SW-1:0] proc_slot_r, proc_slot_nxt;
  logic          adv;
  logic          more;

  assign adv       = !(proc_v_r && sts.blocked);
  assign more      = rd_cnt_r < (SW + 1)'(SLOTS);
  assign in_ready  = (state_r == ST_IDLE);
  assign rd_slot   = rd_cnt_r[SW-1:0];
  assign proc_slot = proc_slot_r;

  always_comb begin
    cmd.start   = in_valid && in_ready;
    cmd.rd_en   = (state_r == ST_SCAN) && adv && more;
    cmd.proc_en = (state_r == ST_SCAN) && proc_v_r && adv;
    cmd.flush   = (state_r == ST_FLUSH);
  end

  always_comb begin
    state_nxt     = state_r;
    rd_cnt_nxt    = rd_cnt_r;
    proc_v_nxt    = proc_v_r;
    proc_slot_nxt = proc_slot_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          rd_cnt_nxt = '0;
          proc_v_nxt = 1'b0;
          state_nxt  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (adv) begin
          proc_v_nxt    = more;
          proc_slot_nxt = rd_cnt_r[SW-1:0];
          if (more) begin
            rd_cnt_nxt = rd_cnt_r + 1'b1;
          end else begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (!sts.pend_v || sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt  = ST_IDLE;
        proc_v_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      rd_cnt_r <= '0;
      proc_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_cnt_r <= rd_cnt_nxt;
      proc_v_r <= proc_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    proc_slot_r <= proc_slot_nxt;
  end

`ifndef NO_ASSERTIONS
  a_idle_no_proc: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !proc_v_r)
    else $error("slot in process stage while idle");

  a_start_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> state_r == ST_SCAN && !proc_v_r)
    else $error("accepted item did not start a scan");

  a_flush_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FLUSH |-> $past(state_r) == ST_SCAN || $past(state_r) == ST_FLUSH)
    else $error("flush entered without a scan");
`endif

endmodule

/* rtl/pdrs_dp.sv */
// Datapath: message store, per-slot queue state, event staging and output register.
module pdrs_dp
  import pdrs_pkg::*;
#(
  parameter int SLOTS      = 8,
  parameter int FIFO_DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  dp_cmd_t                               cmd,
  input  logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] rd_slot,
  input  logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] proc_slot,
  output dp_sts_t                               sts,
  input  cfg_t                                  cfg,
  input  logic                                  in_command,
  input  logic [15:0]                           in_handle,
  input  logic [15:0]                           in_source,
  input  logic [31:0]                           in_stamp,
  input  logic [15:0]                           in_delta,
  pdrs_out_if.source                            out_ch
);

  localparam int PW    = $clog2(FIFO_DEPTH);
  localparam int FW    = $clog2(FIFO_DEPTH + 1);
  localparam int TOTAL = SLOTS * FIFO_DEPTH;
  localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;

  msg_t mem [TOTAL];

  logic [PW-1:0]        head_r [SLOTS];
  logic [FW-1:0]        fill_r [SLOTS];
  logic [15:0]          age_r  [SLOTS];
  logic signed [16:0]   cd_r   [SLOTS];

  logic                 cmd_r;
  msg_t                 item_r;
  logic [15:0]          delta_r;
  logic [CNT_W-1:0]     ev_cnt_r;

  msg_t                 rd_data_r;
  logic [PW-1:0]        rd_head_r;

  logic                 pend_v_r;
  ev_kind_t             pend_kind_r;
  logic [2:0]           pend_slot_r;
  msg_t                 pend_msg_r;
  logic [15:0]          pend_sender_r;

  logic                 out_v_r;
  ev_kind_t             out_kind_r;
  logic [2:0]           out_slot_r;
  msg_t                 out_msg_r;
  logic [15:0]          out_sender_r;
  logic                 out_last_r;

  logic [AW-1:0]        rd_addr;
  logic [AW-1:0]        wr_addr;
  logic [FW-1:0]        fill;
  logic [2:0]           slot3;
  logic                 conn;
  logic                 full;
  logic [PW:0]          pos_sum;
  logic [PW-1:0]        pos;
  logic [PW-1:0]        head_inc;
  logic [16:0]          age_sum;
  logic [15:0]          age_sat;
  logic signed [17:0]   cd_sub;
  logic signed [16:0]   cd_clamp;
  logic                 timeout;
  logic                 resend;
  logic                 enq_write;
  logic                 tick_act;
  logic                 ev_raw;
  ev_kind_t             ev_kind;
  msg_t                 ev_msg;
  logic                 room;
  logic                 emit;
  logic                 out_free;
  logic                 push_mid;
  logic                 push_last;

  assign rd_addr = AW'(rd_slot) * AW'(FIFO_DEPTH) + AW'(head_r[rd_slot]);

  assign fill    = fill_r[proc_slot];
  assign slot3   = 3'(proc_slot);
  assign conn    = (32'(proc_slot) < 32'd8) && cfg.mask[slot3];
  assign full    = (fill == FW'(FIFO_DEPTH));
  assign pos_sum = (PW + 1)'(rd_head_r) + (PW + 1)'(fill);
  assign pos     = (pos_sum >= (PW + 1)'(FIFO_DEPTH)) ?
                   PW'(pos_sum - (PW + 1)'(FIFO_DEPTH)) : PW'(pos_sum);
  assign wr_addr = AW'(proc_slot) * AW'(FIFO_DEPTH) + AW'(pos);
  assign head_inc = (rd_head_r == PW'(FIFO_DEPTH - 1)) ? '0 : rd_head_r + 1'b1;

  assign age_sum  = 17'(age_r[proc_slot]) + 17'(delta_r);
  assign age_sat  = age_sum[16] ? 16'hFFFF : age_sum[15:0];
  assign cd_sub   = 18'(cd_r[proc_slot]) - $signed({2'b00, delta_r});
  assign cd_clamp = (cd_sub < $signed(18'h30000)) ? $signed(17'h10000) : cd_sub[16:0];
  assign timeout  = (age_sat >= cfg.timeout);
  assign resend   = !timeout && (cd_clamp <= 17'sd0);

  assign enq_write = (cmd_r == CMD_ENQ) && conn && !full;
  assign tick_act  = (cmd_r == CMD_TICK) && (fill != '0);

  always_comb begin
    ev_raw  = 1'b0;
    ev_kind = EV_SEND;
    ev_msg  = rd_data_r;
    if (cmd_r == CMD_ENQ) begin
      ev_raw  = conn && full;
      ev_kind = EV_FULL;
      ev_msg  = item_r;
    end else if (tick_act) begin
      if (timeout) begin
        ev_raw  = 1'b1;
        ev_kind = EV_TIMEOUT;
      end else begin
        ev_raw  = resend && conn;
        ev_kind = EV_SEND;
      end
    end
  end

  assign room      = ev_cnt_r < CNT_W'(MAX_RESULTS);
  assign out_free  = !out_v_r || out_ch.ready;
  assign emit      = cmd.proc_en && ev_raw && room;
  assign push_mid  = emit && pend_v_r;
  assign push_last = cmd.flush && pend_v_r && out_free;

  always_comb begin
    sts.blocked  = ev_raw && room && pend_v_r && !out_free;
    sts.pend_v   = pend_v_r;
    sts.out_free = out_free;
  end

  // Item latch
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cmd_r          <= in_command;
      item_r.handle  <= in_handle;
      item_r.source  <= (in_source == 16'd0) ? cfg.own_id : in_source;
      item_r.stamp   <= in_stamp;
      delta_r        <= in_delta;
    end
  end

  // Message store
  always_ff @(posedge clk) begin
    if (cmd.proc_en && enq_write) begin
      mem[wr_addr] <= item_r;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_head_r <= head_r[rd_slot];
    end
  end

  // Per-slot queue state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        head_r[i] <= '0;
        fill_r[i] <= '0;
        age_r[i]  <= '0;
        cd_r[i]   <= '0;
      end
    end else if (cmd.proc_en) begin
      if (enq_write) begin
        fill_r[proc_slot] <= fill + FW'(1);
        if (fill == '0) begin
          age_r[proc_slot] <= '0;
          cd_r[proc_slot]  <= '0;
        end
      end else if (tick_act) begin
        if (timeout) begin
          head_r[proc_slot] <= head_inc;
          fill_r[proc_slot] <= fill - FW'(1);
          age_r[proc_slot]  <= '0;
          cd_r[proc_slot]   <= '0;
        end else begin
          age_r[proc_slot] <= age_sat;
          cd_r[proc_slot]  <= resend ? $signed({1'b0, cfg.resend}) : cd_clamp;
        end
      end
    end
  end

  // Event staging: the held event learns whether it is the last one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      ev_cnt_r <= '0;
      out_v_r  <= 1'b0;
    end else begin
      if (cmd.start) begin
        ev_cnt_r <= '0;
      end else if (emit) begin
        ev_cnt_r <= ev_cnt_r + 1'b1;
      end
      if (emit) begin
        pend_v_r <= 1'b1;
      end else if (push_last) begin
        pend_v_r <= 1'b0;
      end
      if (push_mid || push_last) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pend_kind_r   <= ev_kind;
      pend_slot_r   <= slot3;
      pend_msg_r    <= ev_msg;
      pend_sender_r <= cfg.own_id;
    end
    if (push_mid || push_last) begin
      out_kind_r   <= pend_kind_r;
      out_slot_r   <= pend_slot_r;
      out_msg_r    <= pend_msg_r;
      out_sender_r <= pend_sender_r;
      out_last_r   <= push_last;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.event_kind = out_kind_r;
  assign out_ch.dest_slot  = out_slot_r;
  assign out_ch.out_handle = out_msg_r.handle;
  assign out_ch.out_stamp  = out_msg_r.stamp;
  assign out_ch.out_source = out_msg_r.source;
  assign out_ch.sender_id  = out_sender_r;
  assign out_ch.last_event = out_last_r;

`ifndef NO_ASSERTIONS
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    ev_cnt_r <= CNT_W'(MAX_RESULTS))
    else $error("event count beyond limit");

  a_block_cause: assert property (@(posedge clk) disable iff (!rst_n)
    sts.blocked |-> pend_v_r && out_v_r && !out_ch.ready)
    else $error("stall without a full output path");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    push_last |=> !pend_v_r && out_v_r && out_last_r)
    else $error("final beat not staged");
`endif

endmodule
